>>> design/cal6_pkg.sv
`timescale 1ns / 1ps
package cal6_pkg;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_CANCEL = 2'd2;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_CAPT    = 3'd2;
  localparam logic [2:0] ST_FACE    = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;
  localparam logic [2:0] ST_TIMEOUT = 3'd5;
  localparam logic [2:0] ST_CANCEL  = 3'd6;
  localparam logic [2:0] ST_BADSPAN = 3'd7;

  localparam logic [2:0] FACE_FRONT   = 3'd0;
  localparam logic [2:0] FACE_BACK    = 3'd1;
  localparam logic [2:0] FACE_UP      = 3'd2;
  localparam logic [2:0] FACE_DOWN    = 3'd3;
  localparam logic [2:0] FACE_LEFT    = 3'd4;
  localparam logic [2:0] FACE_RIGHT   = 3'd5;
  localparam logic [2:0] FACE_UNKNOWN = 3'd6;

  localparam logic [2:0] REG_THRESH  = 3'd0;
  localparam logic [2:0] REG_STILL   = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_CAPTURE = 3'd3;
  localparam logic [2:0] REG_GRAVITY = 3'd4;

  localparam int THRESH_W = 34;
  localparam int CNT_W    = 16;
  localparam int CAPN_W   = 12;
  localparam int GRAV_W   = 16;
  localparam int CFG_W    = 34;

  localparam logic [THRESH_W-1:0] THRESH_RST  = 34'd252004;
  localparam logic [CNT_W-1:0]    STILL_RST   = 16'd1200;
  localparam logic [CNT_W-1:0]    TIMEOUT_RST = 16'd4000;
  localparam logic [CAPN_W-1:0]   CAPN_RST    = 12'd2000;
  localparam logic [GRAV_W-1:0]   GRAV_RST    = 16'd10045;

  localparam logic [5:0] ALL_FACES = 6'h3F;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_CAPT = 2'd2
  } mode_t;

  function automatic logic [2:0] popcount6(input logic [5:0] v);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 6; i++) begin
      n = n + {2'b00, v[i]};
    end
    return n;
  endfunction

endpackage

>>> design/cal6_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module cal6_div #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        den_r  <= den;
        q_r    <= num;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> design/six_face_accel_scale_calibrator_unit.sv
`timescale 1ns / 1ps
// Six-face accelerometer scale calibrator.
// Input words arrive on in_* (tuser = request: sample, start or cancel; tdata =
// x, y, z samples). Every input word yields exactly one result word on out_*
// (tuser = status; tdata = stage, face and three Q2.F scale factors).
// Registers are written on cfg_* by index (0 motion threshold, 1 still count,
// 2 timeout, 3 capture count, 4 two g) and are always accepted.
// One word is processed at a time, and in_tready is low while it is at work.
// Start, cancel, idle and timed-out samples go from S_EXEC straight to S_OUT, any
// other waiting sample through S_MUL and S_DECIDE first (the squared change norm
// goes through one shared multiplier, one axis per cycle), a capturing sample
// straight to S_OUT. The last sample of a face adds a serial division of an NW-bit
// numerator (NW = 33 at default parameters) for the mean, and the sixth face,
// unless a span is bad, three more for the scales. All share one restoring divider.
// A finished word waits in the output register while the receiver stalls;
// the next input word is accepted meanwhile and held until the slot is free.
// Reset (rst_n low, synchronous) returns the block to idle with default
// registers and an empty output register.
module six_face_accel_scale_calibrator_unit
  import cal6_pkg::*;
#(
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 16,
  localparam int IN_TDW  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_TDW = ((6 + 3 * (SCALE_FRAC_BITS + 2) + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,  // req_type
  input  logic [IN_TDW-1:0]     in_tdata,  // accel_x, accel_y, accel_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [2:0]            out_tuser, // status
  output logic [OUT_TDW-1:0]    out_tdata, // stage, face, scale_x, scale_y, scale_z
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int SB      = SAMPLE_BITS;
  localparam int SCW     = SCALE_FRAC_BITS + 2;
  localparam int SUMW    = SB + CAPN_W;
  localparam int MNW     = SUMW + 1;
  localparam int SNW     = ((GRAV_W + SCALE_FRAC_BITS > SB) ?
                            (GRAV_W + SCALE_FRAC_BITS) : SB) + 1;
  localparam int NW      = (MNW > SNW) ? MNW : SNW;
  localparam int DW      = SB + 1;
  localparam int PW      = 2 * SB + 2;
  localparam int NRMW    = PW + 2;

  typedef enum logic [3:0] {
    S_ACC, S_EXEC, S_MUL, S_DECIDE, S_MSTART, S_MDIV, S_SPAN,
    S_SSTART, S_SDIV, S_OUT
  } state_t;

  state_t state_r;
  mode_t  mode_r;

  logic [THRESH_W-1:0] thresh_r;
  logic [CNT_W-1:0]    still_need_r;
  logic [CNT_W-1:0]    tlimit_r;
  logic [CAPN_W-1:0]   capn_r;
  logic [GRAV_W-1:0]   grav_r;

  logic [5:0]          faces_done_r;
  logic [CNT_W-1:0]    still_r;
  logic [CNT_W-1:0]    tout_r;
  logic [CAPN_W-1:0]   cap_cnt_r;
  logic [2:0]          cap_face_r;
  logic signed [SUMW-1:0] cap_sum_r;
  logic signed [SB-1:0] prev_r [3];
  logic signed [SB-1:0] means_r [6];

  logic [1:0]          req_r;
  logic signed [SB-1:0] ax_r [3];
  logic [1:0]          k_r;
  logic [PW-1:0]       prod_r;
  logic [NRMW-1:0]     norm_r;
  logic [2:0]          status_r;
  logic [2:0]          face_r;
  logic [SCW-1:0]      scale_r [3];
  logic                mean_neg_r;

  logic                out_valid_r;
  logic [2:0]          out_status_r;
  logic [2:0]          out_stage_r;
  logic [2:0]          out_face_r;
  logic [SCW-1:0]      out_scale_r [3];

  logic                div_start_r;
  logic [NW-1:0]       div_num_r;
  logic [DW-1:0]       div_den_r;
  logic                div_done;
  logic [NW-1:0]       div_quo;

  cal6_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Squared difference for the axis selected by k_r.
  logic [1:0]           kidx;
  logic signed [SB:0]   diff;
  logic [SB:0]          mag;
  logic [PW-1:0]        sq;

  assign kidx = (k_r == 2'd3) ? 2'd0 : k_r;
  assign diff = {ax_r[kidx][SB-1], ax_r[kidx]} - {prev_r[kidx][SB-1], prev_r[kidx]};
  assign mag  = diff[SB] ? (SB+1)'(-diff) : diff;
  assign sq   = mag * mag;

  // Face detection from the latched sample.
  logic [SB:0] abx, aby, abz;
  logic [2:0]  det_face;

  assign abx = ax_r[0][SB-1] ? (SB+1)'(-{ax_r[0][SB-1], ax_r[0]}) : {1'b0, ax_r[0]};
  assign aby = ax_r[1][SB-1] ? (SB+1)'(-{ax_r[1][SB-1], ax_r[1]}) : {1'b0, ax_r[1]};
  assign abz = ax_r[2][SB-1] ? (SB+1)'(-{ax_r[2][SB-1], ax_r[2]}) : {1'b0, ax_r[2]};

  always_comb begin
    if (abx > aby && abx > abz) begin
      det_face = ax_r[0][SB-1] ? FACE_FRONT : FACE_BACK;
    end else if (aby > abx && aby > abz) begin
      det_face = ax_r[1][SB-1] ? FACE_RIGHT : FACE_LEFT;
    end else if (abz > abx && abz > aby) begin
      det_face = ax_r[2][SB-1] ? FACE_DOWN : FACE_UP;
    end else begin
      det_face = FACE_UNKNOWN;
    end
  end

  logic [CNT_W-1:0]  tout_inc, still_inc, still_new;
  logic [CAPN_W-1:0] cap_n, cnt_inc;
  logic signed [SB-1:0] axis_val;
  logic signed [SUMW-1:0] sum_inc;
  logic [SUMW-1:0]   sum_abs;
  logic              face_free;

  assign tout_inc  = (tout_r == '1) ? tout_r : tout_r + 1'b1;
  assign still_inc = (still_r == '1) ? still_r : still_r + 1'b1;
  assign still_new = (norm_r > NRMW'(thresh_r)) ? '0 : still_inc;
  assign cap_n     = (capn_r == '0) ? CAPN_W'(1) : capn_r;
  assign cnt_inc   = cap_cnt_r + 1'b1;
  assign face_free = (det_face != FACE_UNKNOWN) && !faces_done_r[det_face];

  always_comb begin
    if (cap_face_r == FACE_FRONT || cap_face_r == FACE_BACK) begin
      axis_val = ax_r[0];
    end else if (cap_face_r == FACE_UP || cap_face_r == FACE_DOWN) begin
      axis_val = ax_r[2];
    end else begin
      axis_val = ax_r[1];
    end
  end

  assign sum_inc = cap_sum_r + SUMW'(axis_val);
  assign sum_abs = cap_sum_r[SUMW-1] ? SUMW'(-cap_sum_r) : cap_sum_r;

  // Spans between the positive and negative face of each axis.
  logic signed [SB:0] span [3];
  logic               bad_span;
  logic [SB:0]        span_sel;
  logic signed [SB-1:0] mean_val;
  logic [SCW-1:0]     scale_sat;

  assign span[0]  = {means_r[1][SB-1], means_r[1]} - {means_r[0][SB-1], means_r[0]};
  assign span[1]  = {means_r[4][SB-1], means_r[4]} - {means_r[5][SB-1], means_r[5]};
  assign span[2]  = {means_r[2][SB-1], means_r[2]} - {means_r[3][SB-1], means_r[3]};
  assign bad_span = (span[0] <= 0) || (span[1] <= 0) || (span[2] <= 0);
  assign span_sel = span[kidx];
  assign mean_val = mean_neg_r ? SB'(-div_quo[SB-1:0]) : div_quo[SB-1:0];
  assign scale_sat = (|div_quo[NW-1:SCW]) ? '1 : div_quo[SCW-1:0];

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_ACC);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_ACC;
      mode_r       <= MODE_IDLE;
      faces_done_r <= '0;
      still_r      <= '0;
      tout_r       <= '0;
      cap_cnt_r    <= '0;
      cap_face_r   <= '0;
      cap_sum_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i] <= '0;
      end
      thresh_r     <= THRESH_RST;
      still_need_r <= STILL_RST;
      tlimit_r     <= TIMEOUT_RST;
      capn_r       <= CAPN_RST;
      grav_r       <= GRAV_RST;
      out_valid_r  <= 1'b0;
      div_start_r  <= 1'b0;
      k_r          <= '0;
    end else begin
      div_start_r <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_THRESH:  thresh_r     <= cfg_data[THRESH_W-1:0];
          REG_STILL:   still_need_r <= cfg_data[CNT_W-1:0];
          REG_TIMEOUT: tlimit_r     <= cfg_data[CNT_W-1:0];
          REG_CAPTURE: capn_r       <= cfg_data[CAPN_W-1:0];
          REG_GRAVITY: grav_r       <= cfg_data[GRAV_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_ACC: begin
          if (in_tvalid) begin
            req_r    <= in_tuser;
            ax_r[0]  <= in_tdata[SB-1:0];
            ax_r[1]  <= in_tdata[2*SB-1:SB];
            ax_r[2]  <= in_tdata[3*SB-1:2*SB];
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          face_r  <= FACE_UNKNOWN;
          for (int i = 0; i < 3; i++) begin
            scale_r[i] <= '0;
          end
          unique case (mode_r)
            MODE_WAIT: status_r <= ST_WAIT;
            MODE_CAPT: status_r <= ST_CAPT;
            default:   status_r <= ST_IDLE;
          endcase
          state_r <= S_OUT;
          unique case (req_r)
            REQ_START: begin
              mode_r       <= MODE_WAIT;
              faces_done_r <= '0;
              still_r      <= '0;
              tout_r       <= '0;
              cap_cnt_r    <= '0;
              cap_sum_r    <= '0;
              status_r     <= ST_WAIT;
            end
            REQ_CANCEL: begin
              if (mode_r != MODE_IDLE) begin
                mode_r   <= MODE_IDLE;
                status_r <= ST_CANCEL;
              end
            end
            REQ_SAMPLE: begin
              if (mode_r == MODE_WAIT) begin
                tout_r <= tout_inc;
                if (tlimit_r != '0 && tout_inc >= tlimit_r) begin
                  mode_r   <= MODE_IDLE;
                  status_r <= ST_TIMEOUT;
                end else begin
                  k_r     <= '0;
                  prod_r  <= '0;
                  norm_r  <= '0;
                  state_r <= S_MUL;
                end
              end else if (mode_r == MODE_CAPT) begin
                face_r    <= cap_face_r;
                cap_sum_r <= sum_inc;
                cap_cnt_r <= cnt_inc;
                if (cnt_inc >= cap_n) begin
                  state_r <= S_MSTART;
                end
              end
            end
            default: ;
          endcase
        end
        S_MUL: begin
          // One axis per cycle; the adder sums the product that the multiplier left in prod_r.
          norm_r <= norm_r + NRMW'(prod_r);
          if (k_r != 2'd3) begin
            prod_r       <= sq;
            prev_r[kidx] <= ax_r[kidx];
            k_r          <= k_r + 1'b1;
          end else begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_OUT;
          if (still_new >= still_need_r) begin
            still_r <= '0;
            face_r  <= det_face;
            if (face_free) begin
              mode_r     <= MODE_CAPT;
              cap_face_r <= det_face;
              cap_cnt_r  <= '0;
              cap_sum_r  <= '0;
              status_r   <= ST_CAPT;
            end
          end else begin
            still_r <= still_new;
          end
        end
        S_MSTART: begin
          div_start_r <= 1'b1;
          div_num_r   <= NW'(sum_abs) + NW'(cap_n[CAPN_W-1:1]);
          div_den_r   <= DW'(cap_n);
          mean_neg_r  <= cap_sum_r[SUMW-1];
          state_r     <= S_MDIV;
        end
        S_MDIV: begin
          if (div_done) begin
            means_r[cap_face_r]      <= mean_val;
            faces_done_r[cap_face_r] <= 1'b1;
            still_r                  <= '0;
            tout_r                   <= '0;
            state_r                  <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (faces_done_r != ALL_FACES) begin
            mode_r   <= MODE_WAIT;
            status_r <= ST_FACE;
            state_r  <= S_OUT;
          end else begin
            mode_r <= MODE_IDLE;
            if (bad_span) begin
              status_r <= ST_BADSPAN;
              state_r  <= S_OUT;
            end else begin
              k_r     <= '0;
              state_r <= S_SSTART;
            end
          end
        end
        S_SSTART: begin
          div_start_r <= 1'b1;
          div_num_r   <= (NW'(grav_r) << SCALE_FRAC_BITS) + NW'(span_sel[SB:1]);
          div_den_r   <= span_sel;
          state_r     <= S_SDIV;
        end
        S_SDIV: begin
          if (div_done) begin
            scale_r[kidx] <= scale_sat;
            if (k_r == 2'd2) begin
              status_r <= ST_DONE;
              state_r  <= S_OUT;
            end else begin
              k_r     <= k_r + 1'b1;
              state_r <= S_SSTART;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_stage_r  <= popcount6(faces_done_r);
            out_face_r   <= face_r;
            for (int i = 0; i < 3; i++) begin
              out_scale_r[i] <= scale_r[i];
            end
            state_r <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDW'({out_scale_r[2], out_scale_r[1], out_scale_r[0],
                               out_face_r, out_stage_r});

endmodule

>>> design/cal6_checker.sv
`timescale 1ns / 1ps
module cal6_checker
  import cal6_pkg::*;
#(
  parameter int SCW     = 18,
  parameter int OUT_TDW = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [2:0]         out_tuser,
  input logic [OUT_TDW-1:0] out_tdata
);

  // A result held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // Each word is worked on alone: the input closes right after acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a word is at work");

  // A finished calibration has all six faces captured.
  a_done_stage: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_DONE |-> out_tdata[2:0] == 3'd6)
    else $error("done reported with faces missing");

  // Scales are zero unless the calibration has just finished.
  a_scale_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tdata[6+3*SCW-1:6] == '0)
    else $error("scale reported outside done");

endmodule

bind six_face_accel_scale_calibrator_unit cal6_checker #(
  .SCW     (SCALE_FRAC_BITS + 2),
  .OUT_TDW (OUT_TDW)
) u_cal6_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

>>> test/cal6_checker.sv
`timescale 1ns / 1ps
module cal6_scoreboard
  import cal6_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [1:0]       in_tuser,  // req_type
  input  logic [47:0]      in_tdata,  // accel_x, accel_y, accel_z
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [2:0]       out_tuser, // status
  input  logic [63:0]      out_tdata, // stage, face, scale_x, scale_y, scale_z
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [2:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending,
  output int               scales_seen
);

  typedef struct {
    logic [2:0]  status;
    logic [2:0]  stage;
    logic [2:0]  face;
    logic [17:0] scale [3];
  } cal_word_t;

  localparam longint unsigned SCALE_SAT = 64'd262143;

  cal_word_t expected_words[$];

  logic [THRESH_W-1:0] motion_thr;
  logic [CNT_W-1:0]    still_req;
  logic [CNT_W-1:0]    tmo_lim;
  logic [CAPN_W-1:0]   cap_n;
  logic [GRAV_W-1:0]   two_g;

  mode_t       mode;
  logic [5:0]  faces_done;
  int          still_cnt;
  int          tmo_cnt;
  int          cap_cnt;
  logic [2:0]  cap_face;
  longint      cap_sum;
  longint      prev_acc [3];
  longint      face_mean [6];

  assign pending = expected_words.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic calib_step(input logic [1:0] req, input logic [47:0] acc);
    cal_word_t w;
    longint a [3];
    longint m [3];
    longint d, n, mean, q;
    longint span [3];
    longint unsigned norm;
    bit bad;
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'($signed(acc[16*i +: 16]));
      m[i] = a[i] < 0 ? -a[i] : a[i];
      w.scale[i] = '0;
    end
    w.status = mode == MODE_WAIT ? ST_WAIT : (mode == MODE_CAPT ? ST_CAPT : ST_IDLE);
    w.face = FACE_UNKNOWN;
    if (req == REQ_START) begin
      mode = MODE_WAIT;
      faces_done = '0;
      still_cnt = 0;
      tmo_cnt = 0;
      cap_cnt = 0;
      cap_sum = 0;
      w.status = ST_WAIT;
    end else if (req == REQ_CANCEL) begin
      if (mode != MODE_IDLE) begin
        mode = MODE_IDLE;
        w.status = ST_CANCEL;
      end
    end else if (req == REQ_SAMPLE && mode == MODE_WAIT) begin
      if (tmo_cnt < 65535) tmo_cnt++;
      if (tmo_lim != 0 && tmo_cnt >= tmo_lim) begin
        mode = MODE_IDLE;
        w.status = ST_TIMEOUT;
      end else begin
        norm = 0;
        for (int i = 0; i < 3; i++) begin
          d = a[i] - prev_acc[i];
          if (d < 0) d = -d;
          norm += longint'(d * d);
          prev_acc[i] = a[i];
        end
        if (norm > motion_thr) still_cnt = 0;
        else if (still_cnt < 65535) still_cnt++;
        if (still_cnt >= still_req) begin
          still_cnt = 0;
          if (m[0] > m[1] && m[0] > m[2]) w.face = a[0] < 0 ? FACE_FRONT : FACE_BACK;
          else if (m[1] > m[0] && m[1] > m[2]) w.face = a[1] < 0 ? FACE_RIGHT : FACE_LEFT;
          else if (m[2] > m[0] && m[2] > m[1]) w.face = a[2] < 0 ? FACE_DOWN : FACE_UP;
          if (w.face != FACE_UNKNOWN && !faces_done[w.face]) begin
            mode = MODE_CAPT;
            cap_face = w.face;
            cap_cnt = 0;
            cap_sum = 0;
            w.status = ST_CAPT;
          end
        end
      end
    end else if (req == REQ_SAMPLE && mode == MODE_CAPT) begin
      n = cap_n == 0 ? 1 : longint'(cap_n);
      w.face = cap_face;
      cap_sum += a[cap_face < 2 ? 0 : (cap_face < 4 ? 2 : 1)];
      cap_cnt++;
      if (cap_cnt >= n) begin
        // Mean rounds to nearest with ties away from zero.
        if (cap_sum >= 0) mean = (cap_sum + n / 2) / n;
        else mean = -((-cap_sum + n / 2) / n);
        face_mean[cap_face] = mean;
        faces_done[cap_face] = 1'b1;
        still_cnt = 0;
        tmo_cnt = 0;
        if (faces_done != ALL_FACES) begin
          mode = MODE_WAIT;
          w.status = ST_FACE;
        end else begin
          mode = MODE_IDLE;
          span[0] = face_mean[FACE_BACK] - face_mean[FACE_FRONT];
          span[1] = face_mean[FACE_LEFT] - face_mean[FACE_RIGHT];
          span[2] = face_mean[FACE_UP] - face_mean[FACE_DOWN];
          bad = 0;
          for (int i = 0; i < 3; i++) if (span[i] <= 0) bad = 1;
          if (bad) begin
            w.status = ST_BADSPAN;
          end else begin
            for (int i = 0; i < 3; i++) begin
              q = ((longint'(two_g) << 16) + span[i] / 2) / span[i];
              w.scale[i] = longint'(q) > longint'(SCALE_SAT) ? SCALE_SAT[17:0] : q[17:0];
            end
            w.status = ST_DONE;
          end
        end
      end
    end
    w.stage = popcount6(faces_done);
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    cal_word_t e;
    if (!rst_n) begin
      motion_thr = THRESH_RST;
      still_req = STILL_RST;
      tmo_lim = TIMEOUT_RST;
      cap_n = CAPN_RST;
      two_g = GRAV_RST;
      mode = MODE_IDLE;
      faces_done = '0;
      still_cnt = 0;
      tmo_cnt = 0;
      cap_cnt = 0;
      cap_face = '0;
      cap_sum = 0;
      for (int i = 0; i < 3; i++) prev_acc[i] = 0;
      for (int i = 0; i < 6; i++) face_mean[i] = 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          REG_THRESH:  motion_thr = cfg_data[THRESH_W-1:0];
          REG_STILL:   still_req = cfg_data[CNT_W-1:0];
          REG_TIMEOUT: tmo_lim = cfg_data[CNT_W-1:0];
          REG_CAPTURE: cap_n = cfg_data[CAPN_W-1:0];
          REG_GRAVITY: two_g = cfg_data[GRAV_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = expected_words.pop_front();
          if (out_tuser !== e.status)
            report($sformatf("status %0d, expected %0d", out_tuser, e.status));
          if (out_tdata[2:0] !== e.stage)
            report($sformatf("stage %0d, expected %0d", out_tdata[2:0], e.stage));
          if (out_tdata[5:3] !== e.face)
            report($sformatf("face %0d, expected %0d", out_tdata[5:3], e.face));
          for (int i = 0; i < 3; i++)
            if (out_tdata[6 + 18*i +: 18] !== e.scale[i])
              report($sformatf("scale axis %0d is %0d, expected %0d",
                               i, out_tdata[6 + 18*i +: 18], e.scale[i]));
          if (out_tdata[63:60] !== 4'd0) report("padding bits of result not zero");
          if (e.status == ST_DONE) scales_seen++;
        end
      end
      if (in_tvalid && in_tready) calib_step(in_tuser, in_tdata);
    end
  end

  initial begin
    errors = 0;
    scales_seen = 0;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;
  import cal6_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [1:0]       in_tuser;  // req_type
  logic [47:0]      in_tdata;  // accel_x, accel_y, accel_z
  logic             out_tvalid;
  logic             out_tready;
  logic [2:0]       out_tuser; // status
  logic [63:0]      out_tdata; // stage, face, scale_x, scale_y, scale_z
  logic             cfg_valid;
  logic             cfg_ready;
  logic [2:0]       cfg_addr;
  logic [CFG_W-1:0] cfg_data;

  int errors, pending, scales_seen;
  int words_sent, runs_started, stall_cycles;
  int cur_still, cur_capn;
  bit no_gaps, hold_now;

  six_face_accel_scale_calibrator_unit DUT (.*);

  cal6_scoreboard chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .out_tvalid, .out_tready, .out_tuser, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .errors, .pending, .scales_seen
  );

  always #4 clk = ~clk;

  initial begin
    clk = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 0;
    cfg_valid = 0;
    cfg_addr = '0;
    cfg_data = '0;
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  initial begin
    hold_now = 0;
    forever begin
      if (hold_now) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_now = 0;
      end else begin
        out_tready <= no_gaps || $urandom_range(99) >= 37;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == 20000) begin
      $display("[six_face_accel_scale_calibrator_unit] ERROR");
      $finish;
    end
  end

  task automatic send(input logic [1:0] req, input logic [15:0] x, y, z);
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (!no_gaps && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drops the offer right after the last accepted word so that it is not
  // taken a second time once the unit is ready again.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] thr, input int still, tmo, capn, grav);
    logic [CFG_W-1:0] vals [5];
    vals = '{thr, still, tmo, capn, grav};
    wait_idle();
    in_tvalid <= 1'b0;
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_still = still;
    cur_capn = capn == 0 ? 1 : capn;
  endtask

  // Holds the unit still on one face long enough to detect it, then feeds
  // the capture words. A flipped face averages the wrong sign.
  task automatic face_seq(input logic [2:0] f, input int mag, input bit flip);
    logic signed [15:0] v [3];
    int ax, sgn;
    ax = f < 2 ? 0 : (f < 4 ? 2 : 1);
    sgn = (f == FACE_BACK || f == FACE_LEFT || f == FACE_UP) ? 1 : -1;
    for (int i = 0; i < 3; i++)
      v[i] = $urandom_range(1) ? $urandom_range(0, mag / 2) : -$urandom_range(0, mag / 2);
    v[ax] = sgn * mag;
    repeat (cur_still + 1) send(REQ_SAMPLE, v[0], v[1], v[2]);
    repeat (cur_capn) begin
      for (int i = 0; i < 3; i++) v[i] = $urandom;
      v[ax] = (flip ? -sgn : sgn) * mag + $urandom_range(0, 63) - 32;
      send(REQ_SAMPLE, v[0], v[1], v[2]);
    end
  endtask

  task automatic calibrate();
    logic [2:0] order [6];
    logic [2:0] t;
    int j;
    runs_started++;
    for (int i = 0; i < 6; i++) order[i] = i;
    for (int i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    send(REQ_START, $urandom, $urandom, $urandom);
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(99) < 5) send($urandom_range(0, 3), $urandom, $urandom, $urandom);
      face_seq(order[i], $urandom_range(3000, 30000), $urandom_range(99) < 8);
    end
  endtask

  initial begin
    words_sent = 0;
    runs_started = 0;
    stall_cycles = 0;
    no_gaps = 0;
    cur_still = 1200;
    cur_capn = 2000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: requests in idle and waiting mode, extreme samples, unused code.
    send(REQ_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFFF);
    send(2'd3, 16'h8000, 16'h7FFF, 16'h0000);
    send(REQ_CANCEL, 0, 0, 0);
    send(REQ_START, 0, 0, 0);
    send(REQ_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send(REQ_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send(2'd3, 0, 0, 0);
    send(REQ_CANCEL, 0, 0, 0);
    send(REQ_START, 0, 0, 0);
    send(REQ_START, 0, 0, 0);

    // Zero threshold, single-word captures, timeout off, largest gravity.
    set_regs('0, 1, 0, 1, 65535);
    send(REQ_START, 0, 0, 0);
    send(REQ_SAMPLE, 1000, 1000, 5);
    send(REQ_SAMPLE, 1000, 1000, 5);
    face_seq(FACE_FRONT, 5000, 0);
    face_seq(FACE_FRONT, 5000, 0);
    face_seq(FACE_BACK, 5000, 0);
    face_seq(FACE_UP, 32000, 0);
    face_seq(FACE_DOWN, 32000, 0);
    face_seq(FACE_LEFT, 20, 0);
    face_seq(FACE_RIGHT, 20, 0);

    // Upper extremes of the count registers, a large threshold, smallest nonzero gravity.
    set_regs(34'd12884901888, 65535, 65535, 4095, 1);
    send(REQ_START, 0, 0, 0);
    repeat (4) send(REQ_SAMPLE, $urandom, $urandom, $urandom);
    send(REQ_CANCEL, 0, 0, 0);

    // One long capture, then cancel in the middle of waiting.
    set_regs(1000, 1, 0, 200, 10045);
    send(REQ_START, 0, 0, 0);
    face_seq(FACE_DOWN, 16000, 0);
    send(REQ_CANCEL, 0, 0, 0);

    // Immediate timeout.
    set_regs(50000, 2, 1, 3, 10045);
    send(REQ_START, 0, 0, 0);
    send(REQ_SAMPLE, 100, 200, 300);
    send(REQ_SAMPLE, 100, 200, 300);

    hold_now = 1;
    for (int k = 0; k < 1550; ) begin
      if (k % 300 < 60)
        set_regs($urandom_range(0, 400000), $urandom_range(1, 4),
                 $urandom_range(1) ? 0 : $urandom_range(20, 120),
                 $urandom_range(1, 6), $urandom_range(1, 65535));
      no_gaps = k >= 700 && k < 1000;
      j_loop: begin
        int before_cnt;
        before_cnt = words_sent;
        if ($urandom_range(99) < 80) calibrate();
        else repeat ($urandom_range(1, 6)) send($urandom_range(0, 3), $urandom, $urandom, $urandom);
        k += words_sent - before_cnt;
      end
    end
    no_gaps = 0;
    @(posedge clk);
    wait_idle();
    repeat (200) @(posedge clk);

    $display("Sent %0d request words in %0d calibration runs; %0d runs produced scales.",
             words_sent, runs_started, scales_seen);
    $display("Registers swept from zero to full range, including timeout and bad span runs.");
    if (errors == 0 && pending == 0) begin
      $display("[six_face_accel_scale_calibrator_unit] OK");
    end else begin
      $display("[six_face_accel_scale_calibrator_unit] ERROR");
    end
    $finish;
  end

endmodule
